// File: sv/tilt_compass_attitude_assert.svh
// Assertion macros for the tilt compass attitude checker.
// Depends on nothing; included by the checker file.
`ifndef TILT_COMPASS_ATTITUDE_ASSERT_SVH
`define TILT_COMPASS_ATTITUDE_ASSERT_SVH
// implication checked every clock edge outside reset
`define TCA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tca: assertion failed");
// signal never true outside reset
`define TCA_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("tca: forbidden condition");
`endif

// File: sv/tca_pkg.sv
// Package for the tilt compass attitude block: widths, CORDIC constants.
// Depends on nothing.
`default_nettype none
package tca_pkg;
  localparam int SAMPLE_BITS = 16;
  localparam int STEPS = 24;
  localparam int PITCH_W = 15;
  localparam int ROLL_W = 16;
  localparam int HEAD_W = 17;
  localparam int DECL_W = 16;
  // CORDIC datapath: samples times 2^16, plus gain and add headroom
  localparam int DW = SAMPLE_BITS + 16 + 4;
  localparam int ZW = 33;
  localparam int GAIN_Q16 = 107922;
  localparam longint DEG180 = 64'd1800000000;
  localparam longint DEG90 = 64'd900000000;
  localparam int CENTI = 100000;
  localparam logic [DECL_W-1:0] DECL_RESET = 16'd362;

  // special case codes, carried with each lane
  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_ZERO = 2'd1;
  localparam logic [1:0] SP_PI = 2'd2;
  localparam logic [1:0] SP_HALF = 2'd3;

  typedef logic signed [DW-1:0] dat_t;
  typedef logic signed [ZW-1:0] ang_t;

  function automatic ang_t atan_tab(input int i);
    unique case (i)
      0: atan_tab = 33'sd450000000;  1: atan_tab = 33'sd265650512;
      2: atan_tab = 33'sd140362435;  3: atan_tab = 33'sd71250163;
      4: atan_tab = 33'sd35763344;   5: atan_tab = 33'sd17899106;
      6: atan_tab = 33'sd8951737;    7: atan_tab = 33'sd4476142;
      8: atan_tab = 33'sd2238105;    9: atan_tab = 33'sd1119057;
      10: atan_tab = 33'sd559529;    11: atan_tab = 33'sd279765;
      12: atan_tab = 33'sd139882;    13: atan_tab = 33'sd69941;
      14: atan_tab = 33'sd34971;     15: atan_tab = 33'sd17485;
      16: atan_tab = 33'sd8743;      17: atan_tab = 33'sd4371;
      18: atan_tab = 33'sd2186;      19: atan_tab = 33'sd1093;
      20: atan_tab = 33'sd546;       21: atan_tab = 33'sd273;
      22: atan_tab = 33'sd137;       23: atan_tab = 33'sd68;
      default: atan_tab = '0;
    endcase
  endfunction

  // special case code of an atan2(y, x) operand pair
  function automatic logic [1:0] sp_code(input dat_t y, input dat_t x);
    if (y == '0 && x == '0) sp_code = SP_ZERO;
    else if (y == '0) sp_code = (x > 0) ? SP_ZERO : SP_PI;
    else if (x == '0) sp_code = SP_HALF;
    else sp_code = SP_NONE;
  endfunction
endpackage
`default_nettype wire

// File: sv/tca_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Depends on tca_pkg.
`default_nettype none
module tca_cordic
  import tca_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  dat_t      in_y,
  input  dat_t      in_x,
  output logic      out_valid,
  output ang_t      out_angle,
  output dat_t      out_mag
);
  logic        v [STEPS+1];
  dat_t        xs [STEPS+1];
  dat_t        ys [STEPS+1];
  ang_t        zs [STEPS+1];
  logic [1:0]  sp [STEPS+1];
  logic        ypos [STEPS+1];
  dat_t        x0, y0;
  ang_t        z0;

  // pre-rotate into the right half plane
  always_comb begin
    x0 = in_x;
    y0 = in_y;
    z0 = '0;
    if (in_x < 0) begin
      z0 = (in_y >= 0) ? ang_t'(DEG180) : -ang_t'(DEG180);
      x0 = -in_x;
      y0 = -in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_valid;
    xs[0] <= x0;
    ys[0] <= y0;
    zs[0] <= z0;
    sp[0] <= sp_code(in_y, in_x);
    ypos[0] <= (in_y > 0);
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    dat_t sx, sy;
    assign sx = xs[i] >>> i;
    assign sy = ys[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
      if (ys[i] < 0) begin
        xs[i+1] <= xs[i] - sy;
        ys[i+1] <= ys[i] + sx;
        zs[i+1] <= zs[i] - atan_tab(i);
      end else begin
        xs[i+1] <= xs[i] + sy;
        ys[i+1] <= ys[i] - sx;
        zs[i+1] <= zs[i] + atan_tab(i);
      end
      sp[i+1] <= sp[i];
      ypos[i+1] <= ypos[i];
    end
  end

  always_comb begin
    unique case (sp[STEPS])
      SP_ZERO: out_angle = '0;
      SP_PI:   out_angle = ang_t'(DEG180);
      SP_HALF: out_angle = ypos[STEPS] ? ang_t'(DEG90) : -ang_t'(DEG90);
      default: out_angle = zs[STEPS];
    endcase
  end
  assign out_valid = v[STEPS];
  assign out_mag = xs[STEPS];
endmodule
`default_nettype wire

// File: sv/tilt_compass_attitude.sv
// Top level of the tilt compensated compass attitude block.
// Depends on tca_pkg and tca_cordic.
//
// Use: drive accel_x/y/z, mag_x, mag_y and pulse start; busy is always low,
// so a new sample word may be taken on every clock edge.
// Roll and heading run through two 25-stage CORDIC pipelines side by side.
// Pitch needs the roll magnitude, so it runs through a third CORDIC that
// starts once the roll magnitude leaves the first; a delay line holds
// accel_x until then, and it is gain-scaled at the delay line's end.
// Path from the accepting edge to done: the input register loads at the
// accepting edge, then the two CORDIC pipelines run in series, then a
// rounding stage and the output register.
// Throughput: one word per cycle.
// done strobes for one cycle with pitch_angle, roll_angle, heading_angle;
// the receiver cannot stall, so nothing is held.
// Configuration: cfg_valid/cfg_ready write declination; cfg_ready is always
// high. Write only while no word is in flight.
// Reset (rst, synchronous): clears every valid bit, declination to 3.62 deg.
`default_nettype none
module tilt_compass_attitude
  import tca_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_x,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_y,
  input  wire logic signed [SAMPLE_BITS-1:0] accel_z,
  input  wire logic signed [SAMPLE_BITS-1:0] mag_x,
  input  wire logic signed [SAMPLE_BITS-1:0] mag_y,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic signed [DECL_W-1:0]      cfg_data,
  output logic                               done,
  output logic signed [PITCH_W-1:0]          pitch_angle,
  output logic signed [ROLL_W-1:0]           roll_angle,
  output logic signed [HEAD_W-1:0]           heading_angle
);
  localparam int LAT = STEPS + 1;
  localparam longint HALFC = CENTI / 2;
  // ceil(2^39 / 3125): exact quotient for any dividend below 2^27
  localparam logic [27:0] RECIP3125 = 28'd175921861;

  logic signed [DECL_W-1:0] declination;
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) declination <= DECL_RESET;
    else if (cfg_valid) declination <= cfg_data;
  end

  // stage 0: register the sample word scaled by 2^16; accel_x is kept unscaled
  logic v_in;
  dat_t ry, rx, hy, hx;
  logic my_zero, mx_neg;
  logic signed [SAMPLE_BITS-1:0] ax_r;
  always_ff @(posedge clk) begin
    if (rst) v_in <= 1'b0;
    else v_in <= start;
    ry <= dat_t'(accel_y) <<< 16;
    rx <= dat_t'(accel_z) <<< 16;
    hy <= dat_t'(mag_x) <<< 16;
    hx <= dat_t'(mag_y) <<< 16;
    my_zero <= (mag_y == '0);
    mx_neg <= mag_x[SAMPLE_BITS-1];
    ax_r <= accel_x;
  end

  logic rv, hv, pv;
  ang_t roll_z, head_z, pitch_z;
  dat_t roll_mag, unused_a, unused_b;

  tca_cordic u_roll (.clk, .rst, .in_valid(v_in), .in_y(ry), .in_x(rx),
    .out_valid(rv), .out_angle(roll_z), .out_mag(roll_mag));
  tca_cordic u_head (.clk, .rst, .in_valid(v_in), .in_y(hy), .in_x(hx),
    .out_valid(hv), .out_angle(head_z), .out_mag(unused_a));

  // delay line for accel_x and heading special case, one multiply at its end
  logic signed [SAMPLE_BITS-1:0] ax_d [LAT];
  logic hz_d [LAT], hn_d [LAT];
  always_ff @(posedge clk) begin
    ax_d[0] <= ax_r;
    hz_d[0] <= my_zero;
    hn_d[0] <= mx_neg;
    for (int i = 1; i < LAT; i++) begin
      ax_d[i] <= ax_d[i-1];
      hz_d[i] <= hz_d[i-1];
      hn_d[i] <= hn_d[i-1];
    end
  end
  dat_t py;
  assign py = -(dat_t'(ax_d[LAT-1]) * dat_t'(GAIN_Q16));

  // hold roll and heading until pitch is done
  ang_t roll_q [LAT], head_q [LAT];
  always_ff @(posedge clk) begin
    roll_q[0] <= roll_z;
    head_q[0] <= hz_d[LAT-1] ? (hn_d[LAT-1] ? ang_t'(DEG180) : '0) : head_z;
    for (int i = 1; i < LAT; i++) begin
      roll_q[i] <= roll_q[i-1];
      head_q[i] <= head_q[i-1];
    end
  end
  logic hv_unused;
  assign hv_unused = hv;

  tca_cordic u_pitch (.clk, .rst, .in_valid(rv & hv_unused), .in_y(py),
    .in_x(roll_mag), .out_valid(pv), .out_angle(pitch_z), .out_mag(unused_b));

  // declination and wrap
  logic signed [34:0] hd, hw;
  always_comb begin
    hd = 35'(head_q[LAT-1]) - 35'(declination) * 35'(CENTI);
    priority if (hd > 35'(DEG180)) hw = hd - 35'(2 * DEG180);
    else if (hd < -35'(DEG180)) hw = hd + 35'(2 * DEG180);
    else if (hd < 0) hw = hd + 35'(2 * DEG180);
    else hw = hd;
  end

  // magnitude plus half a step; every angle here stays below 2^32 in size
  function automatic logic [31:0] mag_half(input logic signed [34:0] a);
    logic signed [34:0] m;
    m = a[34] ? -a : a;
    mag_half = m[31:0] + 32'(HALFC);
  endfunction

  // divide by 100000 as a shift by 5 and a reciprocal multiply for 3125,
  // then restore the sign: rounds half away from zero to hundredths
  function automatic logic signed [16:0] centi(input logic [31:0] t, input logic neg);
    logic [54:0] p;
    logic signed [16:0] q;
    p = {28'd0, t[31:5]} * {27'd0, RECIP3125};
    q = $signed({1'b0, p[54:39]});
    centi = neg ? -q : q;
  endfunction

  // stage: register sign and magnitude plus half
  logic v_r;
  logic [31:0] p_m, r_m, h_m;
  logic p_n, r_n, h_n;
  always_ff @(posedge clk) begin
    if (rst) v_r <= 1'b0;
    else v_r <= pv;
    p_m <= mag_half(35'(pitch_z));
    p_n <= pitch_z[ZW-1];
    r_m <= mag_half(35'(roll_q[LAT-1]));
    r_n <= roll_q[LAT-1][ZW-1];
    h_m <= mag_half(hw);
    h_n <= hw[34];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v_r;
    pitch_angle <= PITCH_W'(centi(p_m, p_n));
    roll_angle <= ROLL_W'(centi(r_m, r_n));
    heading_angle <= HEAD_W'(centi(h_m, h_n));
  end
endmodule
`default_nettype wire

// File: sv/tca_checker.sv
// Port checker for tilt_compass_attitude, bound to the top level.
// Depends on tca_pkg and tilt_compass_attitude_assert.svh.
`default_nettype none
`include "tilt_compass_attitude_assert.svh"
module tca_port_checker
  import tca_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic busy,
  input wire logic done,
  input wire logic signed [PITCH_W-1:0] pitch_angle,
  input wire logic signed [HEAD_W-1:0] heading_angle
);
  `TCA_ASSERT_NEVER(a_busy_low, busy)
  `TCA_ASSERT_IMP(a_pitch_range, done,
    pitch_angle <= 15'sd9000 && pitch_angle >= -15'sd9000)
  `TCA_ASSERT_IMP(a_head_range, done, heading_angle <= 17'sd54000)
  `TCA_ASSERT_IMP(a_done_after_reset, $past(rst), !done)
endmodule

bind tilt_compass_attitude tca_port_checker u_tca_checker (.clk, .rst, .busy,
  .done, .pitch_angle, .heading_angle);
`default_nettype wire

// File: dv/tca_checker.sv
// Attitude checker: watches the sample, configuration and result channels of
// tilt_compass_attitude, predicts each result and compares it. Depends on tca_pkg.
`timescale 1ns / 1ps
module tca_checker
  import tca_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic signed [SAMPLE_BITS-1:0] mag_x,
  input  logic signed [SAMPLE_BITS-1:0] mag_y,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic signed [DECL_W-1:0]      cfg_data,
  input  logic                          done,
  input  logic signed [PITCH_W-1:0]     pitch_angle,
  input  logic signed [ROLL_W-1:0]      roll_angle,
  input  logic signed [HEAD_W-1:0]      heading_angle,
  output int                            fail_count,
  output int                            angles_pending
);
  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [ROLL_W-1:0]  roll;
    logic [HEAD_W-1:0]  head;
  } attitude_t;

  localparam longint ATAN_DEG7 [24] = '{
    450000000, 265650512, 140362435, 71250163, 35763344, 17899106,
    8951737, 4476142, 2238105, 1119057, 559529, 279765,
    139882, 69941, 34971, 17485, 8743, 4371,
    2186, 1093, 546, 273, 137, 68};

  attitude_t angles_q[$];
  longint    decl_now;

  // atan2(y, x) in 1e-7 degree; gained magnitude returned through mag
  function automatic longint atan2_deg7(input longint y0, input longint x0,
                                        output longint mag);
    longint x, y, z, xs, ys;
    x = x0; y = y0; z = 0;
    if (x < 0) begin
      z = (y >= 0) ? DEG180 : -DEG180;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x -= ys; y += xs; z -= ATAN_DEG7[i];
      end else begin
        x += ys; y -= xs; z += ATAN_DEG7[i];
      end
    end
    mag = x;
    if (x0 == 0 && y0 == 0) return 0;
    if (y0 == 0) return (x0 > 0) ? 0 : DEG180;
    if (x0 == 0) return (y0 > 0) ? DEG90 : -DEG90;
    return z;
  endfunction

  function automatic longint centi_round(input longint a);
    if (a >= 0) return (a + CENTI / 2) / CENTI;
    return -((-a + CENTI / 2) / CENTI);
  endfunction

  function automatic attitude_t predict_attitude(input longint ax, ay, az, mx, my);
    longint mag, spare, roll, pitch, head;
    attitude_t a;
    roll  = atan2_deg7(ay * 65536, az * 65536, mag);
    pitch = atan2_deg7(-ax * GAIN_Q16, mag, spare);
    if (my == 0) head = (mx < 0) ? DEG180 : 0;
    else head = atan2_deg7(mx * 65536, my * 65536, spare);
    head -= decl_now * CENTI;
    if (head > DEG180) head -= 2 * DEG180;
    else if (head < -DEG180) head += 2 * DEG180;
    else if (head < 0) head += 2 * DEG180;
    a.pitch = PITCH_W'(centi_round(pitch));
    a.roll  = ROLL_W'(centi_round(roll));
    a.head  = HEAD_W'(centi_round(head));
    return a;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  assign angles_pending = angles_q.size();

  always @(posedge clk) begin
    attitude_t want;
    if (rst) begin
      decl_now = 362;
      angles_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) decl_now = cfg_data;
      // compare before queueing, so a result never meets the prediction of the word accepted with it
      if (done) begin
        if (angles_q.size() == 0) begin
          $display("%0t: result word with nothing outstanding", $time);
          fail_count++;
        end else begin
          want = angles_q.pop_front();
          if (pitch_angle !== want.pitch)
            report_mismatch("pitch", pitch_angle, $signed(want.pitch));
          if (roll_angle !== want.roll)
            report_mismatch("roll", roll_angle, $signed(want.roll));
          if (heading_angle !== want.head)
            report_mismatch("heading", heading_angle, $signed(want.head));
        end
      end
      if (start && !busy)
        angles_q.push_back(predict_attitude(accel_x, accel_y, accel_z, mag_x, mag_y));
    end
  end
endmodule

// File: dv/tb.sv
// Testbench top for tilt_compass_attitude: clock, reset, sample and declination
// stimulus, verdict. Depends on tca_pkg and the tca_checker module.
`timescale 1ns / 1ps
module tb;
  import tca_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;   // comfortably past the pipeline depth

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, cfg_ready, done;
  logic signed [SAMPLE_BITS-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [SAMPLE_BITS-1:0] mag_x = '0, mag_y = '0;
  logic cfg_valid = 1'b0;
  logic signed [DECL_W-1:0] cfg_data = '0;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [HEAD_W-1:0]  heading_angle;
  int fail_count, angles_pending;
  int cycle_count = 0;

  always #5 clk = ~clk;

  tilt_compass_attitude dut (
    .clk, .rst, .start, .busy, .accel_x, .accel_y, .accel_z, .mag_x, .mag_y,
    .cfg_valid, .cfg_ready, .cfg_data, .done, .pitch_angle, .roll_angle,
    .heading_angle
  );

  tca_checker chk (
    .clk, .rst, .start, .busy, .accel_x, .accel_y, .accel_z, .mag_x, .mag_y,
    .cfg_valid, .cfg_ready, .cfg_data, .done, .pitch_angle, .roll_angle,
    .heading_angle, .fail_count, .angles_pending
  );

  // Watchdog: end the run if the pipeline hangs or stimulus never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Hold start high across back-to-back words; drop it only for a real gap.
  task automatic send_sample(input logic signed [15:0] ax, ay, az, mx, my, input int gap);
    start   <= 1'b1;
    accel_x <= ax; accel_y <= ay; accel_z <= az;
    mag_x   <= mx; mag_y   <= my;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly back-to-back, a few short gaps, the odd long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Axis value: full range, small magnitude, zero, or an extreme.
  function automatic logic signed [15:0] pick_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom);
    if (r < 80) return 16'($signed($urandom_range(0, 600)) - 300);
    if (r < 90) return 16'sd0;
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd1;
      default: return -16'sd1;
    endcase
  endfunction

  // Write declination only with the pipeline empty, then let it settle.
  task automatic write_declination(input logic signed [15:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (angles_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++)
      send_sample(pick_axis(), pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                  (i % 40 < 8) ? 0 : idle_gap());
  endtask

  initial begin
    logic signed [15:0] decl_set [6];
    decl_set = '{-16'sd18000, 16'sd18000, 16'sd0, 16'sh8000, 16'sh7fff, 16'sd362};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero operands, axis-aligned vectors, extremes, mag_y zero.
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(0, 0, 100, 0, 100, 0);
    send_sample(0, 0, -100, 0, -100, 0);
    send_sample(0, 100, 0, 100, 0, 1);
    send_sample(0, -100, 0, -100, 0, 0);
    send_sample(100, 0, 0, 0, 0, 0);
    send_sample(-100, 0, 0, 5, 0, 2);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 3);
    send_sample(16'sh7fff, 0, 1, -1, 0, 0);
    send_sample(16'sh8000, 1, 0, 1, -1, 0);
    send_sample(0, 16'sh8000, 0, 0, 16'sh8000, 0);
    send_sample(3, -4, 5, -7, 7, 0);
    send_sample(-3, 4, -5, 7, -7, 0);
    send_sample(1000, 1000, 1000, -1, 1, 0);

    // Random words, declination swept through its extremes and beyond.
    random_burst(150);
    foreach (decl_set[k]) begin
      write_declination(decl_set[k]);
      send_sample(0, 0, 100, 0, 100, 0);
      send_sample(0, 0, 100, -100, 0, 0);
      random_burst(110);
    end
    write_declination(16'($signed($urandom_range(0, 36000)) - 18000));
    random_burst(100);

    start <= 1'b0;
    @(posedge clk);
    while (angles_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
